[sv/leaky_bucket_flood_limiter_defines.svh]
// ----------------------------------------------------------------------------
// leaky bucket flood limiter assertion macros
// shared property wrappers, clocked and disabled by the synchronous reset
// ----------------------------------------------------------------------------
`ifndef LEAKY_BUCKET_FLOOD_LIMITER_DEFINES_SVH
`define LEAKY_BUCKET_FLOOD_LIMITER_DEFINES_SVH

// same-cycle implication
`define LBFL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("leaky bucket flood limiter: same-cycle check failed");

// next-cycle implication
`define LBFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("leaky bucket flood limiter: next-cycle check failed");

`endif

[sv/lbfl_pkg.sv]
// ----------------------------------------------------------------------------
// lbfl_pkg
// widths, codes, reset values and controller/datapath interface types
// ----------------------------------------------------------------------------
package lbfl_pkg;

    localparam int OP_W       = 2;
    localparam int TICK_W     = 32;
    localparam int COST_W     = 12;
    localparam int FILL_W     = 24;
    localparam int TS_W       = 20;
    localparam int PEN_W      = 16;
    localparam int THR_W      = 16;
    localparam int WARN_W     = 8;
    localparam int VERD_W     = 2;
    localparam int SIL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int FRAC_W     = 8;
    localparam int DVD_W      = TICK_W + FRAC_W;
    localparam int STEP_W     = 6;
    localparam int PROD_W     = FILL_W + 1 + TS_W + 1;
    localparam int SUM_W      = PROD_W + 1;

    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DVD_W);

    localparam logic [OP_W-1:0] OP_CHECK      = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET_TIME = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET_SPAM = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP        = 2'd3;

    localparam logic [VERD_W-1:0] VERDICT_OK   = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_MILD = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_HARD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_WARNINGS = 2'd3;

    localparam logic [TS_W-1:0]   RST_TIME_SCALE     = 20'd4000;
    localparam logic [PEN_W-1:0]  RST_PENALTY        = 16'd0;
    localparam logic [THR_W-1:0]  RST_KICK_THRESHOLD = 16'd5120;
    localparam logic [WARN_W-1:0] RST_KICK_WARNINGS  = 8'd3;

    localparam logic [FILL_W-1:0] SIX_UNITS = 24'd1536;
    localparam logic [FILL_W-1:0] FILL_MAX  = 24'hFFFFFF;
    localparam logic [TS_W-1:0]   MIN_SCALE = 20'd10;
    localparam logic [WARN_W-1:0] WARN_MAX  = 8'hFF;
    localparam logic [TICK_W-1:0] TICK_MAX  = 32'hFFFFFFFF;
    localparam logic [SIL_W-1:0]  SIL_POS_MAX = 32'h7FFFFFFF;
    localparam logic [SIL_W-1:0]  SIL_NEG_MIN = 32'h80000000;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_start;
        logic drain;
        logic judge;
        logic mul;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_check;
        logic div_done;
    } t_status;

endpackage

[sv/leaky_bucket_flood_limiter.sv]
// ----------------------------------------------------------------------------
// leaky_bucket_flood_limiter
// per-source leaky bucket flood limiter with serial drain divider
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_opcode, i_now_ticks, i_cost
//   out      output     o_out_valid / i_out_stall o_verdict, o_silence_ticks
//   cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// a check transaction steps through prep, div, drain, judge, mul and sil from
// acceptance until the input is free again; the drain divider retires one
// quotient bit per cycle over 40 bits. other opcodes skip div, drain and judge.
// one transaction is in flight at a time; the result register holds it while
// the output is stalled, and the next input is taken once the result is loaded.
// synchronous active-low reset restores register defaults and empties the bucket.
// ----------------------------------------------------------------------------
module leaky_bucket_flood_limiter #(
    parameter int AHEAD_TICKS = 1000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lbfl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lbfl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lbfl_pkg::OP_W-1:0]         i_opcode,
    input  logic [lbfl_pkg::TICK_W-1:0]       i_now_ticks,
    input  logic [lbfl_pkg::COST_W-1:0]       i_cost,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lbfl_pkg::VERD_W-1:0]       o_verdict,
    output logic signed [lbfl_pkg::SIL_W-1:0] o_silence_ticks
);
    import lbfl_pkg::*;

    t_cmd    cmd;
    t_status status;

    lbfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lbfl_datapath #(
        .AHEAD_TICKS (AHEAD_TICKS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_opcode),
        .i_now_ticks     (i_now_ticks),
        .i_cost          (i_cost),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_verdict       (o_verdict),
        .o_silence_ticks (o_silence_ticks)
    );

endmodule

[sv/lbfl_div.sv]
// ----------------------------------------------------------------------------
// lbfl_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lbfl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lbfl_pkg::DVD_W-1:0]  i_dividend,
    input  logic [lbfl_pkg::TS_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [lbfl_pkg::DVD_W-1:0]  o_quotient
);
    import lbfl_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0]  r_dvd, n_dvd;
    logic [TS_W-1:0]   r_rem, n_rem;
    logic [TS_W-1:0]   r_dsr, n_dsr;
    logic [TS_W+1:0]   trial;
    logic              fits;

    assign trial = {1'b0, r_rem, r_dvd[DVD_W-1]} - {2'b00, r_dsr};
    assign fits  = !trial[TS_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_STEPS;
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // quotient bits shift in where dividend bits leave
            n_dvd = {r_dvd[DVD_W-2:0], fits};
            n_rem = fits ? trial[TS_W-1:0] : {r_rem[TS_W-2:0], r_dvd[DVD_W-1]};
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

[sv/lbfl_datapath.sv]
// ----------------------------------------------------------------------------
// lbfl_datapath
// bucket state, configuration registers, drain, penalty and silence math
// ----------------------------------------------------------------------------
module lbfl_datapath #(
    parameter int AHEAD_TICKS = 1000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lbfl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lbfl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [lbfl_pkg::OP_W-1:0]       i_opcode,
    input  logic [lbfl_pkg::TICK_W-1:0]     i_now_ticks,
    input  logic [lbfl_pkg::COST_W-1:0]     i_cost,
    input  lbfl_pkg::t_cmd                  i_cmd,
    output lbfl_pkg::t_status               o_status,
    output logic [lbfl_pkg::VERD_W-1:0]     o_verdict,
    output logic signed [lbfl_pkg::SIL_W-1:0] o_silence_ticks
);
    import lbfl_pkg::*;

    logic [TS_W-1:0]   r_time_scale;
    logic [PEN_W-1:0]  r_penalty;
    logic [THR_W-1:0]  r_kick_thr;
    logic [WARN_W-1:0] r_kick_warn;

    logic [FILL_W-1:0] r_fill;
    logic [TICK_W-1:0] r_last_time;
    logic [WARN_W-1:0] r_warn;

    logic [OP_W-1:0]   r_op;
    logic [TICK_W-1:0] r_now;
    logic [COST_W-1:0] r_cost;
    logic [VERD_W-1:0] r_verdict;
    logic signed [PROD_W-1:0] r_prod;

    logic [VERD_W-1:0]       r_out_verdict;
    logic signed [SIL_W-1:0] r_out_silence;

    logic [TS_W-1:0]   eff_ts;
    logic [TICK_W-1:0] cur_ticks;
    logic [TICK_W-1:0] elapsed;
    logic [FILL_W:0]   cost_sum;
    logic [FILL_W-1:0] fill_cost;
    logic [DVD_W-1:0]  quotient;
    logic              div_done;
    logic              drain_all;
    logic [FILL_W-1:0] fill_drained;
    logic [FILL_W:0]   pen_sum;
    logic [FILL_W-1:0] fill_pen;
    logic              hard;
    logic [TICK_W:0]   ahead_sum;
    logic [TICK_W-1:0] ahead_time;
    logic signed [FILL_W:0]   fill_off;
    logic signed [TS_W:0]     ts_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_q;
    logic signed [TICK_W:0]   time_diff;
    logic signed [SUM_W-1:0]  sil_sum;
    logic                     sil_fits;
    logic signed [SIL_W-1:0]  sil_sat;

    assign eff_ts = (r_time_scale < MIN_SCALE) ? MIN_SCALE : r_time_scale;

    // time never runs backwards for a check
    assign cur_ticks = (r_now < r_last_time) ? r_last_time : r_now;
    assign elapsed   = cur_ticks - r_last_time;

    assign cost_sum  = {1'b0, r_fill} + (FILL_W+1)'(r_cost);
    assign fill_cost = cost_sum[FILL_W] ? FILL_MAX : cost_sum[FILL_W-1:0];

    lbfl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({elapsed, {FRAC_W{1'b0}}}),
        .i_divisor  (eff_ts),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign drain_all    = quotient >= DVD_W'(r_fill);
    assign fill_drained = drain_all ? '0 : (r_fill - quotient[FILL_W-1:0]);

    assign pen_sum  = {1'b0, r_fill} + (FILL_W+1)'(r_penalty);
    assign fill_pen = pen_sum[FILL_W] ? FILL_MAX : pen_sum[FILL_W-1:0];
    assign hard     = (fill_pen > FILL_W'(r_kick_thr)) && (r_warn >= r_kick_warn);

    assign ahead_sum  = {1'b0, r_now} + (TICK_W+1)'(AHEAD_TICKS);
    assign ahead_time = ahead_sum[TICK_W] ? TICK_MAX : ahead_sum[TICK_W-1:0];

    assign fill_off = $signed({1'b0, r_fill}) - $signed({1'b0, SIX_UNITS});
    assign ts_s     = $signed({1'b0, eff_ts});
    assign prod     = fill_off * ts_s;

    // arithmetic shift gives the floor for negative products too
    assign prod_q    = r_prod >>> FRAC_W;
    assign time_diff = $signed({1'b0, r_now}) - $signed({1'b0, r_last_time});
    assign sil_sum   = SUM_W'(prod_q) + SUM_W'(time_diff);
    assign sil_fits  = (sil_sum[SUM_W-1:SIL_W-1] == '0) || (sil_sum[SUM_W-1:SIL_W-1] == '1);
    assign sil_sat   = sil_fits ? sil_sum[SIL_W-1:0]
                     : (sil_sum[SUM_W-1] ? $signed(SIL_NEG_MIN) : $signed(SIL_POS_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_scale <= RST_TIME_SCALE;
            r_penalty    <= RST_PENALTY;
            r_kick_thr   <= RST_KICK_THRESHOLD;
            r_kick_warn  <= RST_KICK_WARNINGS;
            r_fill       <= '0;
            r_last_time  <= '0;
            r_warn       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIME_SCALE:     r_time_scale <= i_cfg_wdata[TS_W-1:0];
                    CFG_PENALTY:        r_penalty    <= i_cfg_wdata[PEN_W-1:0];
                    CFG_KICK_THRESHOLD: r_kick_thr   <= i_cfg_wdata[THR_W-1:0];
                    CFG_KICK_WARNINGS:  r_kick_warn  <= i_cfg_wdata[WARN_W-1:0];
                endcase
            end
            if (i_cmd.prep) begin
                unique case (r_op)
                    OP_CHECK: begin
                        r_fill      <= fill_cost;
                        r_last_time <= cur_ticks;
                    end
                    OP_RESET_TIME: r_last_time <= ahead_time;
                    OP_RESET_SPAM: begin
                        r_fill <= '0;
                        r_warn <= '0;
                    end
                    OP_NOP: ;
                endcase
            end
            if (i_cmd.drain) begin
                r_fill <= fill_drained;
            end
            if (i_cmd.judge) begin
                if (r_fill > SIX_UNITS) begin
                    r_fill <= fill_pen;
                    // a hard transaction leaves the warnings alone
                    if (!hard && (r_warn != WARN_MAX)) begin
                        r_warn <= r_warn + WARN_W'(1);
                    end
                end else begin
                    r_warn <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_opcode;
            r_now     <= i_now_ticks;
            r_cost    <= i_cost;
            r_verdict <= VERDICT_OK;
        end
        if (i_cmd.judge && (r_fill > SIX_UNITS)) begin
            r_verdict <= hard ? VERDICT_HARD : VERDICT_MILD;
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
        end
        if (i_cmd.load_out) begin
            r_out_verdict <= r_verdict;
            r_out_silence <= sil_sat;
        end
    end

    assign o_status.is_check = (r_op == OP_CHECK);
    assign o_status.div_done = div_done;
    assign o_verdict         = r_out_verdict;
    assign o_silence_ticks   = r_out_silence;

endmodule

[sv/lbfl_ctrl.sv]
// ----------------------------------------------------------------------------
// lbfl_ctrl
// sequencer for one transaction at a time and the output valid flag
// ----------------------------------------------------------------------------
`include "leaky_bucket_flood_limiter_defines.svh"

module lbfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  lbfl_pkg::t_status i_status,
    output lbfl_pkg::t_cmd    o_cmd
);
    import lbfl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_JUDGE = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_SIL   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       in_acc;
    logic       load_out;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;
    // result register frees up when empty or being taken this cycle
    assign load_out   = (r_state == S_SIL) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_PREP;
            S_PREP:  n_state = i_status.is_check ? S_DIV : S_MUL;
            S_DIV:   if (i_status.div_done) n_state = S_DRAIN;
            S_DRAIN: n_state = S_JUDGE;
            S_JUDGE: n_state = S_MUL;
            S_MUL:   n_state = S_SIL;
            S_SIL:   if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.capture   = in_acc;
    assign o_cmd.prep      = (r_state == S_PREP);
    assign o_cmd.div_start = (r_state == S_PREP) && i_status.is_check;
    assign o_cmd.drain     = (r_state == S_DRAIN);
    assign o_cmd.judge     = (r_state == S_JUDGE);
    assign o_cmd.mul       = (r_state == S_MUL);
    assign o_cmd.load_out  = load_out;
    assign o_out_valid     = r_out_valid;

    `LBFL_ASSERT_NEXT(a_accept_to_prep, i_clk, i_rst_n, in_acc, r_state == S_PREP)
    `LBFL_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, load_out, r_out_valid)
    `LBFL_ASSERT_NEXT(a_sil_holds_on_stall, i_clk, i_rst_n,
                      (r_state == S_SIL) && r_out_valid && i_out_stall, r_state == S_SIL)
    `LBFL_ASSERT_SAME(a_div_done_only_in_div, i_clk, i_rst_n,
                      i_status.div_done, r_state == S_DIV)

endmodule
